// ===== design/bu_pkg.sv =====
package bu_pkg;

    // fixed field widths
    localparam int WORD_BITS      = 32;
    localparam int FILL_BITS      = $clog2(WORD_BITS);
    localparam int BYTE_BITS      = 8;
    localparam int SRC_W_BITS     = 4;
    localparam int DST_W_BITS     = 6;
    localparam int OFFSET_BITS    = 31;
    localparam int CFG_DATA_BITS  = 31;
    localparam int CFG_INDEX_BITS = 2;

    // words a single byte may produce, and the per-byte word counter
    localparam int MAX_WORDS  = 8;
    localparam int COUNT_BITS = $clog2(MAX_WORDS + 1);

    // request queue between front and back, depth a power of two
    localparam int Q_DEPTH      = 4;
    localparam int Q_PTR_BITS   = $clog2(Q_DEPTH);
    localparam int Q_LEVEL_BITS = $clog2(Q_DEPTH + 1);

    // register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_SOURCE_WIDTH = 2'd0,
        CFG_DEST_WIDTH   = 2'd1,
        CFG_UNIT_OFFSET  = 2'd2
    } cfg_reg_e;

    localparam logic [SRC_W_BITS-1:0]  SRC_W_RESET  = 4'd1;
    localparam logic [DST_W_BITS-1:0]  DST_W_RESET  = 6'd8;
    localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = '0;

    // clamped configuration seen by the datapath
    typedef struct packed {
        logic [SRC_W_BITS-1:0]  sw;
        logic [DST_W_BITS-1:0]  dw;
        logic [OFFSET_BITS-1:0] offset;
    } cfg_t;

    // one classified source byte
    typedef struct packed {
        logic [BYTE_BITS-1:0]  data;
        logic                  last;
        logic [SRC_W_BITS-1:0] sw;
        logic [BYTE_BITS-1:0]  unit_mask;
    } cmd_t;

    // queue status
    typedef struct packed {
        logic                    full;
        logic [Q_LEVEL_BITS-1:0] level;
    } q_stat_t;

    // source width: zero acts as one, above eight acts as eight
    function automatic logic [SRC_W_BITS-1:0] clamp_sw(input logic [SRC_W_BITS-1:0] w);
        logic [SRC_W_BITS-1:0] r;
        begin
            r = w;
            if (w == '0)
                r = SRC_W_BITS'(1);
            else if (w > SRC_W_BITS'(BYTE_BITS))
                r = SRC_W_BITS'(BYTE_BITS);
            return r;
        end
    endfunction

    // destination width: zero acts as one, above word size acts as word size
    function automatic logic [DST_W_BITS-1:0] clamp_dw(input logic [DST_W_BITS-1:0] w);
        logic [DST_W_BITS-1:0] r;
        begin
            r = w;
            if (w == '0)
                r = DST_W_BITS'(1);
            else if (w > DST_W_BITS'(WORD_BITS))
                r = DST_W_BITS'(WORD_BITS);
            return r;
        end
    endfunction

    // low-bit mask for a clamped source width
    function automatic logic [BYTE_BITS-1:0] src_mask(input logic [SRC_W_BITS-1:0] w);
        logic [BYTE_BITS-1:0] r;
        begin
            if (w >= SRC_W_BITS'(BYTE_BITS))
                r = '1;
            else
                r = (BYTE_BITS'(1) << w) - BYTE_BITS'(1);
            return r;
        end
    endfunction

    // low-bit mask for a clamped destination width
    function automatic logic [WORD_BITS-1:0] dst_mask(input logic [DST_W_BITS-1:0] w);
        logic [WORD_BITS-1:0] r;
        begin
            if (w >= DST_W_BITS'(WORD_BITS))
                r = '1;
            else
                r = (WORD_BITS'(1) << w) - WORD_BITS'(1);
            return r;
        end
    endfunction

endpackage

// ===== design/bu_ifs.sv =====
// source byte channel
interface bu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       last_byte;

    modport source (output valid, output source_byte, output last_byte, input ready);
    modport sink   (input valid, input source_byte, input last_byte, output ready);
endinterface

// packed word channel
interface bu_out_if #(
    parameter int INDEX_BITS = 19
);
    logic                  valid;
    logic                  ready;
    logic [31:0]           packed_word;
    logic [INDEX_BITS-1:0] word_index;
    logic                  last_word;

    modport source (output valid, output packed_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input packed_word, input word_index,
                    input last_word, output ready);
endinterface

// ===== design/bu_front.sv =====
module bu_front
    import bu_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    bu_in_if.sink                     in_ch,
    input  q_stat_t                   q_stat,
    output logic                      push,
    output cmd_t                      push_cmd,
    output cfg_t                      cfg
);

    logic [SRC_W_BITS-1:0]  sw_reg;
    logic [DST_W_BITS-1:0]  dw_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic [SRC_W_BITS-1:0]  sw_c;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg     <= SRC_W_RESET;
            dw_reg     <= DST_W_RESET;
            offset_reg <= OFFSET_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SOURCE_WIDTH: sw_reg     <= cfg_data[SRC_W_BITS-1:0];
                CFG_DEST_WIDTH:   dw_reg     <= cfg_data[DST_W_BITS-1:0];
                CFG_UNIT_OFFSET:  offset_reg <= cfg_data[OFFSET_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // clamped view for the datapath
    assign sw_c       = clamp_sw(sw_reg);
    assign cfg.sw     = sw_c;
    assign cfg.dw     = clamp_dw(dw_reg);
    assign cfg.offset = offset_reg;

    // accept while the queue has room, classify each byte
    assign in_ch.ready        = !q_stat.full;
    assign push               = in_ch.valid && !q_stat.full;
    assign push_cmd.data      = in_ch.source_byte;
    assign push_cmd.last      = in_ch.last_byte;
    assign push_cmd.sw        = sw_c;
    assign push_cmd.unit_mask = src_mask(sw_c);

endmodule

// ===== design/bu_queue.sv =====
module bu_queue
    import bu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cmd_t    push_cmd,
    input  logic    pop,
    output logic    head_valid,
    output cmd_t    head,
    output q_stat_t q_stat
);

    cmd_t                    entry_reg [Q_DEPTH];
    logic [Q_PTR_BITS-1:0]   wr_ptr_reg;
    logic [Q_PTR_BITS-1:0]   rd_ptr_reg;
    logic [Q_LEVEL_BITS-1:0] level_reg;
    logic                    full;

    assign full         = (level_reg == Q_LEVEL_BITS'(Q_DEPTH));
    assign head_valid   = (level_reg != '0);
    assign head         = entry_reg[rd_ptr_reg];
    assign q_stat.full  = full;
    assign q_stat.level = level_reg;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push && !full)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_BITS'(1);
            if (pop && head_valid)
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_BITS'(1);
            if ((push && !full) && !(pop && head_valid))
                level_reg <= level_reg + Q_LEVEL_BITS'(1);
            else if (!(push && !full) && (pop && head_valid))
                level_reg <= level_reg - Q_LEVEL_BITS'(1);
        end
    end

endmodule

// ===== design/bu_back.sv =====
module bu_back
    import bu_pkg::*;
#(
    parameter int INDEX_BITS = 19
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      head_valid,
    input  cmd_t      head,
    output logic      pop,
    bu_out_if.source  out_ch
);

    logic [WORD_BITS-1:0]   acc_reg, acc_next;
    logic [FILL_BITS-1:0]   fill_reg, fill_next;
    logic [INDEX_BITS-1:0]  words_reg, words_next;
    logic [2:0]             pos_reg, pos_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic                   flush_reg, flush_next;

    logic                   out_valid_reg, out_valid_next;
    logic [WORD_BITS-1:0]   out_word_reg, out_word_next;
    logic [INDEX_BITS-1:0]  out_index_reg, out_index_next;
    logic                   out_last_reg, out_last_next;

    logic                   step;
    logic [3:0]             pos_sum;
    logic                   final_unit;
    logic [BYTE_BITS-1:0]   unit;
    logic [WORD_BITS-1:0]   unit_sum;
    logic [WORD_BITS-1:0]   unit_val;
    logic [2*WORD_BITS-1:0] merged;
    logic [DST_W_BITS-1:0]  nfill;
    logic                   full;
    logic                   emit;
    logic [WORD_BITS-1:0]   emit_word;
    logic                   emit_last;
    logic                   run_end;

    // one unit per step: extract, offset, mask, merge at fill position
    assign pos_sum    = {1'b0, pos_reg} + head.sw;
    assign final_unit = pos_sum[3];
    assign unit       = (head.data >> pos_reg) & head.unit_mask;
    assign unit_sum   = {{(WORD_BITS-BYTE_BITS){1'b0}}, unit} + {1'b0, cfg.offset};
    assign unit_val   = unit_sum & dst_mask(cfg.dw);
    assign merged     = {{WORD_BITS{1'b0}}, acc_reg}
                      | ({{WORD_BITS{1'b0}}, unit_val} << fill_reg);
    assign nfill      = {1'b0, fill_reg} + cfg.dw;
    assign full       = nfill[FILL_BITS];

    // back advances whenever the output register can take a word
    assign step = !out_valid_reg || out_ch.ready;

    // unit sequencing and word emission
    always_comb
    begin
        acc_next   = acc_reg;
        fill_next  = fill_reg;
        words_next = words_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        flush_next = flush_reg;
        pop        = 1'b0;
        emit       = 1'b0;
        emit_word  = merged[WORD_BITS-1:0];
        emit_last  = 1'b0;
        run_end    = 1'b0;

        if (step)
        begin
            if (flush_reg)
            begin
                // partial word left behind by a last byte
                emit       = 1'b1;
                emit_word  = acc_reg;
                emit_last  = 1'b1;
                flush_next = 1'b0;
                run_end    = 1'b1;
            end
            else if (head_valid)
            begin
                acc_next  = full ? merged[2*WORD_BITS-1:WORD_BITS] : merged[WORD_BITS-1:0];
                fill_next = nfill[FILL_BITS-1:0];
                emit      = full;
                if (final_unit)
                begin
                    pos_next   = '0;
                    pop        = 1'b1;
                    count_next = '0;
                    if (head.last)
                    begin
                        if (full && (nfill[FILL_BITS-1:0] != '0)
                            && (count_reg < COUNT_BITS'(MAX_WORDS - 1)))
                        begin
                            flush_next = 1'b1;
                        end
                        else
                        begin
                            // final word of the run, partial one dropped on overflow
                            emit      = 1'b1;
                            emit_last = 1'b1;
                            run_end   = 1'b1;
                        end
                    end
                end
                else
                begin
                    pos_next = pos_sum[2:0];
                    if (full)
                        count_next = count_reg + COUNT_BITS'(1);
                end
            end
        end

        if (emit)
            words_next = words_reg + INDEX_BITS'(1);
        if (run_end)
        begin
            acc_next   = '0;
            fill_next  = '0;
            words_next = '0;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        out_index_next = out_index_reg;
        out_last_next  = out_last_reg;
        if (step)
        begin
            out_valid_next = emit;
            if (emit)
            begin
                out_word_next  = emit_word;
                out_index_next = words_reg;
                out_last_next  = emit_last;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            fill_reg      <= '0;
            words_reg     <= '0;
            pos_reg       <= '0;
            count_reg     <= '0;
            flush_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            fill_reg      <= fill_next;
            words_reg     <= words_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            flush_reg     <= flush_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        out_index_reg <= out_index_next;
        out_last_reg  <= out_last_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.packed_word = out_word_reg;
    assign out_ch.word_index  = out_index_reg;
    assign out_ch.last_word   = out_last_reg;

endmodule

// ===== design/bit_unpack_widener.sv =====
// channel   dir  payload                                  request taken when
// in_ch     in   source_byte[7:0], last_byte              valid && ready
// out_ch    out  packed_word[31:0], word_index, last_word valid && ready
// cfg       in   cfg_index[1:0], cfg_data[30:0]           cfg_we
//
// one source unit is packed per cycle in the back part while its output register
// can take a word, so a byte takes ceil(8 / source_width) units: 1 at width 8,
// 8 at width 1; a last byte that leaves both a full and a partial word adds a flush step.
// bytes enter a four-deep queue at one per cycle while it has room and the back part works.
// reset clears configuration to width 1 / width 8 / offset 0 and the run state.
// a stalled output register holds the back part; the front keeps filling the queue.
module bit_unpack_widener
    import bu_pkg::*;
#(
    parameter int INDEX_BITS = 19
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    bu_in_if.sink                     in_ch,
    bu_out_if.source                  out_ch
);

    cfg_t    cfg;
    q_stat_t q_stat;
    logic    q_push;
    cmd_t    q_push_cmd;
    logic    q_pop;
    logic    q_head_valid;
    cmd_t    q_head;

    // accept and classify
    bu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .q_stat    (q_stat),
        .push      (q_push),
        .push_cmd  (q_push_cmd),
        .cfg       (cfg)
    );

    // decoupling queue
    bu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head),
        .q_stat     (q_stat)
    );

    // unit packing and word output
    bu_back #(
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .out_ch     (out_ch)
    );

    // back never retires a byte the queue does not hold
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_head_valid)
        else $error("pop from empty queue");

    // queue level never passes its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.level <= Q_LEVEL_BITS'(Q_DEPTH))
        else $error("queue level above depth");

    // a lone pop drops the level by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !q_push) |=> (q_stat.level == $past(q_stat.level) - Q_LEVEL_BITS'(1)))
        else $error("queue level out of step with pop");

endmodule
